>>> design/font_face_range_matcher_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef FONT_FACE_RANGE_MATCHER_UNIT_MACROS_SVH
`define FONT_FACE_RANGE_MATCHER_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define FFRM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ffrm check failed");

// Clocked assertion that also holds during reset
`define FFRM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ffrm check failed");

`endif

>>> design/ffrm_pkg.sv
package ffrm_pkg;

  localparam int MaxFaces = 256;
  localparam int ValW     = 16;
  localparam int DistW    = 18;
  localparam int SpanW    = 2 * ValW;
  localparam int FaceW    = 3 * SpanW;

  // Axis codes
  localparam logic [1:0] AXIS_WIDTH  = 2'd0;
  localparam logic [1:0] AXIS_SLOPE  = 2'd1;
  localparam logic [1:0] AXIS_WEIGHT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_REQ_WIDTH   = 3'd0;
  localparam logic [2:0] REG_REQ_SLOPE   = 3'd1;
  localparam logic [2:0] REG_REQ_WEIGHT  = 3'd2;
  localparam logic [2:0] REG_NORMAL_STR  = 3'd3;
  localparam logic [2:0] REG_ITALIC_THR  = 3'd4;
  localparam logic [2:0] REG_WSEARCH_LO  = 3'd5;
  localparam logic [2:0] REG_WSEARCH_HI  = 3'd6;

  typedef logic signed [ValW-1:0]  val_t;
  typedef logic signed [DistW-1:0] wide_t;

  typedef struct packed {
    wide_t d;
    val_t  v;
  } dist_t;

  typedef struct packed {
    logic       store;
    logic       start;
    logic       elim;
    logic [1:0] axis;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic have;
    logic out_free;
  } status_t;

  function automatic wide_t wmax(wide_t a, wide_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic wide_t wmin(wide_t a, wide_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic dist_t mk(wide_t d, val_t v);
    dist_t x;
    x.d = d;
    x.v = v;
    return x;
  endfunction

  function automatic dist_t dist_width(val_t lo_in, val_t hi_in, val_t r_in, val_t ns_in,
                                       val_t blo_in, val_t bhi_in);
    wide_t lo, hi, r, ns, blo, bhi;
    dist_t x;
    lo = wide_t'(lo_in); hi = wide_t'(hi_in); r = wide_t'(r_in);
    ns = wide_t'(ns_in); blo = wide_t'(blo_in); bhi = wide_t'(bhi_in);
    if (lo <= r && r <= hi) x = mk('0, r_in);
    else if (r > ns) begin
      if (lo > r) x = mk(lo - r, lo_in);
      else x = mk(wmax(r, bhi) - hi, hi_in);
    end else begin
      if (hi < r) x = mk(r - hi, hi_in);
      else x = mk(lo - wmin(r, blo), lo_in);
    end
    return x;
  endfunction

  function automatic dist_t dist_slope(val_t lo_in, val_t hi_in, val_t r_in,
                                       logic [ValW-2:0] it_in, val_t blo_in, val_t bhi_in);
    wide_t lo, hi, r, it, blo, bhi;
    dist_t x;
    lo = wide_t'(lo_in); hi = wide_t'(hi_in); r = wide_t'(r_in);
    it = wide_t'({1'b0, it_in}); blo = wide_t'(blo_in); bhi = wide_t'(bhi_in);
    if (lo <= r && r <= hi) x = mk('0, r_in);
    else if (r >= it) begin
      if (lo > r) x = mk(lo - r, lo_in);
      else x = mk(wmax(r, bhi) - hi, hi_in);
    end else if (r >= 0) begin
      if (hi >= 0 && hi < r) x = mk(r - hi, hi_in);
      else if (lo > r) x = mk(lo, lo_in);
      else x = mk(wmax(r, bhi) - hi, hi_in);
    end else if (r > -it) begin
      if (lo > r && lo <= 0) x = mk(lo - r, lo_in);
      else if (hi < r) x = mk(-hi, hi_in);
      else x = mk(lo - wmin(r, blo), lo_in);
    end else begin
      if (hi < r) x = mk(r - hi, hi_in);
      else x = mk(lo - wmin(r, blo), lo_in);
    end
    return x;
  endfunction

  function automatic dist_t dist_weight(val_t lo_in, val_t hi_in, val_t r_in, val_t sl_in,
                                        val_t sh_in, val_t blo_in, val_t bhi_in);
    wide_t lo, hi, r, sl, sh, blo, bhi;
    dist_t x;
    lo = wide_t'(lo_in); hi = wide_t'(hi_in); r = wide_t'(r_in);
    sl = wide_t'(sl_in); sh = wide_t'(sh_in); blo = wide_t'(blo_in); bhi = wide_t'(bhi_in);
    if (lo <= r && r <= hi) x = mk('0, r_in);
    else if (r >= sl && r <= sh) begin
      if (lo > r && lo <= sh) x = mk(lo - r, lo_in);
      else if (hi < r) x = mk(sh - hi, hi_in);
      else x = mk(lo - wmin(r, blo), lo_in);
    end else if (r < sl) begin
      if (hi < r) x = mk(r - hi, hi_in);
      else x = mk(lo - wmin(r, blo), lo_in);
    end else begin
      if (lo > r) x = mk(lo - r, lo_in);
      else x = mk(wmax(r, bhi) - hi, hi_in);
    end
    return x;
  endfunction

endpackage

>>> design/ffrm_ram.sv
module ffrm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/ffrm_ctrl.sv
module ffrm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_stall_o,
  input  ffrm_pkg::status_t status_i,
  output ffrm_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       elim_q, elim_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequence the passes: find then drop, per axis
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    elim_d  = elim_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    cmd_o.elim = elim_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.store = in_valid_i;
        if (in_valid_i && last_i) begin
          state_d = ST_START;
          axis_d  = ffrm_pkg::AXIS_WIDTH;
          elim_d  = 1'b0;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.done) begin
          if (!elim_q && status_i.have) begin
            elim_d  = 1'b1;
            state_d = ST_START;
          end else if (axis_q == ffrm_pkg::AXIS_WEIGHT) begin
            state_d = ST_EMIT;
          end else begin
            axis_d  = axis_q + 2'd1;
            elim_d  = 1'b0;
            state_d = ST_START;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= ffrm_pkg::AXIS_WIDTH;
      elim_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      elim_q  <= elim_d;
    end
  end

endmodule

>>> design/ffrm_datapath.sv
module ffrm_datapath #(
  parameter int MaxFaces = ffrm_pkg::MaxFaces
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  ffrm_pkg::cmd_t       cmd_i,
  output ffrm_pkg::status_t    status_o,
  input  logic                 kind_i,
  input  logic signed [15:0]   width_low_i,
  input  logic signed [15:0]   width_high_i,
  input  logic signed [15:0]   slope_low_i,
  input  logic signed [15:0]   slope_high_i,
  input  logic signed [15:0]   weight_low_i,
  input  logic signed [15:0]   weight_high_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           best_index_o,
  output logic                 found_o,
  output logic                 overflow_o
);

  localparam int IdxW = $clog2(MaxFaces);
  localparam int CntW = $clog2(MaxFaces + 1);
  localparam int BigW = (IdxW > 8) ? IdxW : 8;
  localparam logic [CntW-1:0] CapCnt = CntW'(MaxFaces);

  // Configuration registers
  ffrm_pkg::val_t   req_w_q, req_s_q, req_g_q, norm_q, wlo_q, whi_q;
  logic [14:0]      ital_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_w_q <= 16'sd400;
      req_s_q <= 16'sd0;
      req_g_q <= 16'sd1600;
      norm_q  <= 16'sd400;
      ital_q  <= 15'd80;
      wlo_q   <= 16'sd1600;
      whi_q   <= 16'sd2000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ffrm_pkg::REG_REQ_WIDTH:  req_w_q <= cfg_data_i;
        ffrm_pkg::REG_REQ_SLOPE:  req_s_q <= cfg_data_i;
        ffrm_pkg::REG_REQ_WEIGHT: req_g_q <= cfg_data_i;
        ffrm_pkg::REG_NORMAL_STR: norm_q  <= cfg_data_i;
        ffrm_pkg::REG_ITALIC_THR: ital_q  <= cfg_data_i[14:0];
        ffrm_pkg::REG_WSEARCH_LO: wlo_q   <= cfg_data_i;
        ffrm_pkg::REG_WSEARCH_HI: whi_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Set state: count, bounds, flags
  logic [CntW-1:0]  count_q;
  logic             ovf_q, given_q, uvalid_q;
  ffrm_pkg::val_t   bwl_q, bwh_q, bsl_q, bsh_q, bgl_q, bgh_q;
  logic             face_we;

  assign face_we = cmd_i.store && !kind_i && (count_q != CapCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      given_q  <= 1'b0;
      uvalid_q <= 1'b0;
      bwl_q <= '0; bwh_q <= '0; bsl_q <= '0; bsh_q <= '0; bgl_q <= '0; bgh_q <= '0;
    end else if (cmd_i.emit) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      given_q  <= 1'b0;
      uvalid_q <= 1'b0;
      bwl_q <= '0; bwh_q <= '0; bsl_q <= '0; bsh_q <= '0; bgl_q <= '0; bgh_q <= '0;
    end else if (cmd_i.store) begin
      if (kind_i) begin
        given_q <= 1'b1;
        bwl_q <= width_low_i;  bwh_q <= width_high_i;
        bsl_q <= slope_low_i;  bsh_q <= slope_high_i;
        bgl_q <= weight_low_i; bgh_q <= weight_high_i;
      end else if (face_we) begin
        count_q <= count_q + 1'b1;
        if (!given_q) begin
          uvalid_q <= 1'b1;
          if (!uvalid_q || width_low_i < bwl_q)   bwl_q <= width_low_i;
          if (!uvalid_q || width_high_i > bwh_q)  bwh_q <= width_high_i;
          if (!uvalid_q || slope_low_i < bsl_q)   bsl_q <= slope_low_i;
          if (!uvalid_q || slope_high_i > bsh_q)  bsh_q <= slope_high_i;
          if (!uvalid_q || weight_low_i < bgl_q)  bgl_q <= weight_low_i;
          if (!uvalid_q || weight_high_i > bgh_q) bgh_q <= weight_high_i;
        end
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // Scan sequencer over stored faces
  logic [CntW-1:0] cnt_q;
  logic            act_q, pend_q;
  logic [IdxW-1:0] pidx_q;
  logic            issue, done;

  assign issue = act_q && (cnt_q != count_q);
  assign done  = act_q && !issue && !pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      act_q  <= 1'b0;
      pend_q <= 1'b0;
      pidx_q <= '0;
    end else begin
      pend_q <= issue;
      if (issue) begin
        pidx_q <= cnt_q[IdxW-1:0];
        cnt_q  <= cnt_q + 1'b1;
      end
      if (cmd_i.start) begin
        cnt_q <= '0;
        act_q <= 1'b1;
      end else if (done) begin
        act_q <= 1'b0;
      end
    end
  end

  // Face memory and elimination mask
  logic [ffrm_pkg::FaceW-1:0] face_rd;
  logic                       mask_rd, mask_we, mask_wd;
  logic [IdxW-1:0]            face_waddr;

  assign face_waddr = count_q[IdxW-1:0];

  ffrm_ram #(.Width(ffrm_pkg::FaceW), .Depth(MaxFaces)) u_face_ram (
    .clk_i   (clk_i),
    .we_i    (face_we),
    .waddr_i (face_waddr),
    .wdata_i ({weight_high_i, weight_low_i, slope_high_i, slope_low_i,
               width_high_i, width_low_i}),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (face_rd)
  );

  ffrm_ram #(.Width(1), .Depth(MaxFaces)) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mask_we),
    .waddr_i (pidx_q),
    .wdata_i (mask_wd),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (mask_rd)
  );

  // Distance of the face just read on the current axis
  ffrm_pkg::val_t sp_lo, sp_hi;
  ffrm_pkg::dist_t cand;
  logic            elig, inside_v;
  ffrm_pkg::wide_t best_d_q;
  ffrm_pkg::val_t  best_v_q;
  logic            have_q;

  always_comb begin
    case (cmd_i.axis)
      ffrm_pkg::AXIS_WIDTH: begin
        sp_lo = face_rd[15:0];  sp_hi = face_rd[31:16];
        cand  = ffrm_pkg::dist_width(sp_lo, sp_hi, req_w_q, norm_q, bwl_q, bwh_q);
      end
      ffrm_pkg::AXIS_SLOPE: begin
        sp_lo = face_rd[47:32]; sp_hi = face_rd[63:48];
        cand  = ffrm_pkg::dist_slope(sp_lo, sp_hi, req_s_q, ital_q, bsl_q, bsh_q);
      end
      default: begin
        sp_lo = face_rd[79:64]; sp_hi = face_rd[95:80];
        cand  = ffrm_pkg::dist_weight(sp_lo, sp_hi, req_g_q, wlo_q, whi_q, bgl_q, bgh_q);
      end
    endcase
  end

  assign elig     = (cmd_i.axis == ffrm_pkg::AXIS_WIDTH) || !mask_rd;
  assign inside_v = (sp_lo <= best_v_q) && (best_v_q <= sp_hi);
  assign mask_we  = pend_q && cmd_i.elim;
  assign mask_wd  = !inside_v || ((cmd_i.axis != ffrm_pkg::AXIS_WIDTH) && mask_rd);

  // Track nearest value and first survivor
  logic [IdxW-1:0] best_q;
  logic            found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      best_d_q <= '0;
      best_v_q <= '0;
      best_q   <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.start && !cmd_i.elim) begin
        have_q <= 1'b0;
        if (cmd_i.axis == ffrm_pkg::AXIS_WIDTH) begin
          found_q <= 1'b0;
          best_q  <= '0;
        end
      end else if (pend_q && !cmd_i.elim && elig &&
                   (!have_q || cand.d < best_d_q)) begin
        have_q   <= 1'b1;
        best_d_q <= cand.d;
        best_v_q <= cand.v;
      end
      if (mask_we && (cmd_i.axis == ffrm_pkg::AXIS_WEIGHT) && !mask_wd && !found_q) begin
        found_q <= 1'b1;
        best_q  <= pidx_q;
      end
    end
  end

  // Result register
  logic            ovalid_q;
  logic [BigW-1:0] best_ext;

  assign best_ext = BigW'(best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      best_index_o <= found_q ? best_ext[7:0] : 8'd0;
      found_o      <= found_q;
      overflow_o   <= ovf_q;
    end
  end

  assign out_valid_o       = ovalid_q;
  assign status_o.done     = done;
  assign status_o.have     = have_q;
  assign status_o.out_free = !ovalid_q || !out_stall_i;

endmodule

>>> design/font_face_range_matcher_unit.sv
// Font face range matcher. Load faces (kind 0) and an optional bounds item
// (kind 1) one per cycle; the item with last set starts selection, which runs
// find and drop scans for width, slope and weight over the single read port
// of the face memory. Each scan reads the stored faces in turn; the input is
// stalled while selection runs. The configuration port always takes writes
// (index 0..6, others ignored) and is meant to be written while idle.
module font_face_range_matcher_unit #(
  parameter int MAX_FACES = ffrm_pkg::MaxFaces
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [15:0] width_low_i,
  input  logic signed [15:0] width_high_i,
  input  logic signed [15:0] slope_low_i,
  input  logic signed [15:0] slope_high_i,
  input  logic signed [15:0] weight_low_i,
  input  logic signed [15:0] weight_high_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         best_index_o,
  output logic               found_o,
  output logic               overflow_o
);

  ffrm_pkg::cmd_t    cmd;
  ffrm_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  ffrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ffrm_datapath #(.MaxFaces(MAX_FACES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .kind_i        (kind_i),
    .width_low_i   (width_low_i),
    .width_high_i  (width_high_i),
    .slope_low_i   (slope_low_i),
    .slope_high_i  (slope_high_i),
    .weight_low_i  (weight_low_i),
    .weight_high_i (weight_high_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .best_index_o  (best_index_o),
    .found_o       (found_o),
    .overflow_o    (overflow_o)
  );

endmodule

>>> design/ffrm_checker.sv
`include "font_face_range_matcher_unit_macros.svh"

module ffrm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [15:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        kind_i,
  input logic [15:0] width_low_i,
  input logic [15:0] width_high_i,
  input logic [15:0] slope_low_i,
  input logic [15:0] slope_high_i,
  input logic [15:0] weight_low_i,
  input logic [15:0] weight_high_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  best_index_o,
  input logic        found_o,
  input logic        overflow_o
);

  // A stalled result holds
  `FFRM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(best_index_o) && $stable(found_o))

  // No face found means index zero
  `FFRM_ASSERT(a_notfound_zero, clk_i, rst_ni, out_valid_o && !found_o |-> best_index_o == 8'd0)

  // Transfer of the last item makes the block busy
  `FFRM_ASSERT(a_last_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && last_i |=> in_stall_o)

  // A new result appears only out of selection
  `FFRM_ASSERT(a_result_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))

  // Configuration port never blocks
  `FFRM_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o)

endmodule

bind font_face_range_matcher_unit ffrm_checker u_ffrm_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int NumFaces = 256;

  typedef struct {
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } span_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] w_lo;
    logic signed [15:0] w_hi;
    logic signed [15:0] s_lo;
    logic signed [15:0] s_hi;
    logic signed [15:0] g_lo;
    logic signed [15:0] g_hi;
    logic               last;
  } face_item_t;

  typedef struct packed {
    logic [7:0] best_index;
    logic       found;
    logic       overflow;
  } match_t;

  // Directed row: item, plus an optional expected result typed in by hand
  typedef struct packed {
    face_item_t item;
    logic       has_fixed;
    match_t     fixed;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  face_item_t         cur;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         best_index;
  logic               found;
  logic               overflow;

  // Predictor state
  int                 req_w, req_s, req_g, norm_str, ital_thr, wband_lo, wband_hi;
  span_t              w_mem[NumFaces];
  span_t              s_mem[NumFaces];
  span_t              g_mem[NumFaces];
  bit                 dropped[NumFaces];
  int                 wb_lo, wb_hi, sb_lo, sb_hi, gb_lo, gb_hi;
  bit                 union_ok, bounds_set, set_overflow;
  int                 face_cnt;

  match_t             pending_matches[$];
  int                 n_errors;
  int                 n_matches;
  int                 n_found;
  int                 n_overflow;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 hold_off_cycles;

  font_face_range_matcher_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (cur.kind),
    .width_low_i  (cur.w_lo),
    .width_high_i (cur.w_hi),
    .slope_low_i  (cur.s_lo),
    .slope_high_i (cur.s_hi),
    .weight_low_i (cur.g_lo),
    .weight_high_i(cur.g_hi),
    .last_i       (cur.last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .best_index_o (best_index),
    .found_o      (found),
    .overflow_o   (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("** font_face_range_matcher_unit: FAILED **");
    $finish;
  end

  function automatic bit covers(int lo, int hi, int v);
    return lo <= v && v <= hi;
  endfunction

  function automatic int imax(int a, int b);
    return a > b ? a : b;
  endfunction

  function automatic int imin(int a, int b);
    return a < b ? a : b;
  endfunction

  // Distance of one range on one axis to the request; val is the value picked
  function automatic int axis_distance(int axis, int lo, int hi, output int val);
    int r;
    int it;
    it = ital_thr;
    if (axis == int'(ffrm_pkg::AXIS_WIDTH)) begin
      r = req_w;
      if (covers(lo, hi, r)) begin val = r; return 0; end
      if (r > norm_str) begin
        if (lo > r) begin val = lo; return lo - r; end
        val = hi; return imax(r, wb_hi) - hi;
      end
      if (hi < r) begin val = hi; return r - hi; end
      val = lo; return lo - imin(r, wb_lo);
    end else if (axis == int'(ffrm_pkg::AXIS_SLOPE)) begin
      r = req_s;
      if (covers(lo, hi, r)) begin val = r; return 0; end
      if (r >= it) begin
        if (lo > r) begin val = lo; return lo - r; end
        val = hi; return imax(r, sb_hi) - hi;
      end
      if (r >= 0) begin
        if (hi >= 0 && hi < r) begin val = hi; return r - hi; end
        if (lo > r) begin val = lo; return lo; end
        val = hi; return imax(r, sb_hi) - hi;
      end
      if (r > -it) begin
        if (lo > r && lo <= 0) begin val = lo; return lo - r; end
        if (hi < r) begin val = hi; return -hi; end
        val = lo; return lo - imin(r, sb_lo);
      end
      if (hi < r) begin val = hi; return r - hi; end
      val = lo; return lo - imin(r, sb_lo);
    end
    r = req_g;
    if (covers(lo, hi, r)) begin val = r; return 0; end
    if (r >= wband_lo && r <= wband_hi) begin
      if (lo > r && lo <= wband_hi) begin val = lo; return lo - r; end
      if (hi < r) begin val = hi; return wband_hi - hi; end
      val = lo; return lo - imin(r, gb_lo);
    end
    if (r < wband_lo) begin
      if (hi < r) begin val = hi; return r - hi; end
      val = lo; return lo - imin(r, gb_lo);
    end
    if (lo > r) begin val = lo; return lo - r; end
    val = hi; return imax(r, gb_hi) - hi;
  endfunction

  function automatic span_t face_span(int axis, int i);
    if (axis == int'(ffrm_pkg::AXIS_WIDTH)) return w_mem[i];
    if (axis == int'(ffrm_pkg::AXIS_SLOPE)) return s_mem[i];
    return g_mem[i];
  endfunction

  // One narrowing pass: pick nearest value, drop faces that miss it
  function automatic void narrow_axis(int axis);
    bit    have;
    int    best_d, best_v, d, v;
    span_t sp;
    have = 1'b0;
    best_d = 0;
    best_v = 0;
    for (int i = 0; i < face_cnt; i++) begin
      if (!dropped[i]) begin
        sp = face_span(axis, i);
        d = axis_distance(axis, sp.lo, sp.hi, v);
        if (!have || d < best_d) begin
          have = 1'b1; best_d = d; best_v = v;
        end
      end
    end
    if (have) begin
      for (int i = 0; i < face_cnt; i++) begin
        sp = face_span(axis, i);
        if (!covers(sp.lo, sp.hi, best_v)) dropped[i] = 1'b1;
      end
    end
  endfunction

  function automatic void clear_face_set();
    for (int i = 0; i < NumFaces; i++) dropped[i] = 1'b0;
    wb_lo = 0; wb_hi = 0; sb_lo = 0; sb_hi = 0; gb_lo = 0; gb_hi = 0;
    union_ok = 1'b0;
    bounds_set = 1'b0;
    face_cnt = 0;
    set_overflow = 1'b0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      ffrm_pkg::REG_REQ_WIDTH:  req_w = int'($signed(data));
      ffrm_pkg::REG_REQ_SLOPE:  req_s = int'($signed(data));
      ffrm_pkg::REG_REQ_WEIGHT: req_g = int'($signed(data));
      ffrm_pkg::REG_NORMAL_STR: norm_str = int'($signed(data));
      ffrm_pkg::REG_ITALIC_THR: ital_thr = int'(data[14:0]);
      ffrm_pkg::REG_WSEARCH_LO: wband_lo = int'($signed(data));
      ffrm_pkg::REG_WSEARCH_HI: wband_hi = int'($signed(data));
      default: ;
    endcase
  endfunction

  // Predict the match caused by one accepted item; returns 1 if one is due
  function automatic bit predict_match(face_item_t it, output match_t m);
    if (it.kind) begin
      wb_lo = it.w_lo; wb_hi = it.w_hi;
      sb_lo = it.s_lo; sb_hi = it.s_hi;
      gb_lo = it.g_lo; gb_hi = it.g_hi;
      bounds_set = 1'b1;
    end else if (face_cnt < NumFaces) begin
      w_mem[face_cnt] = '{it.w_lo, it.w_hi};
      s_mem[face_cnt] = '{it.s_lo, it.s_hi};
      g_mem[face_cnt] = '{it.g_lo, it.g_hi};
      dropped[face_cnt] = 1'b0;
      face_cnt++;
      if (!bounds_set) begin
        if (!union_ok) begin
          wb_lo = it.w_lo; wb_hi = it.w_hi;
          sb_lo = it.s_lo; sb_hi = it.s_hi;
          gb_lo = it.g_lo; gb_hi = it.g_hi;
          union_ok = 1'b1;
        end else begin
          wb_lo = imin(wb_lo, it.w_lo); wb_hi = imax(wb_hi, it.w_hi);
          sb_lo = imin(sb_lo, it.s_lo); sb_hi = imax(sb_hi, it.s_hi);
          gb_lo = imin(gb_lo, it.g_lo); gb_hi = imax(gb_hi, it.g_hi);
        end
      end
    end else begin
      set_overflow = 1'b1;
    end
    m = '0;
    if (!it.last) return 1'b0;
    for (int i = 0; i < face_cnt; i++) dropped[i] = 1'b0;
    narrow_axis(int'(ffrm_pkg::AXIS_WIDTH));
    narrow_axis(int'(ffrm_pkg::AXIS_SLOPE));
    narrow_axis(int'(ffrm_pkg::AXIS_WEIGHT));
    for (int i = 0; i < face_cnt; i++) begin
      if (!dropped[i] && !m.found) begin
        m.best_index = i[7:0];
        m.found = 1'b1;
      end
    end
    m.overflow = set_overflow;
    clear_face_set();
    return 1'b1;
  endfunction

  // Receiver: random stall, optional long hold-off, compare each transfer
  always @(posedge clk) begin
    match_t exp_m;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_matches++;
        if (found) n_found++;
        if (overflow) n_overflow++;
        if (pending_matches.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected match: idx=%0d found=%0b ovf=%0b",
                     best_index, found, overflow);
        end else begin
          exp_m = pending_matches.pop_front();
          if (best_index !== exp_m.best_index || found !== exp_m.found ||
              overflow !== exp_m.overflow) begin
            n_errors++;
            if (n_errors <= 10)
              $display("match mismatch: exp idx=%0d found=%0b ovf=%0b, got %0d %0b %0b",
                       exp_m.best_index, exp_m.found, exp_m.overflow,
                       best_index, found, overflow);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one item and hold it until it transfers; valid stays up for the next
  task automatic send_item(face_item_t it);
    match_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cur <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_match(it, m)) pending_matches.push_back(m);
  endtask

  task automatic send_row(row_t row);
    match_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cur <= row.item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_match(row.item, m)) begin
      if (row.has_fixed) m = row.fixed;
      pending_matches.push_back(m);
    end
  endtask

  // Let the block drain fully before touching the registers
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_matches.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (1700) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return 16'($urandom_range(3200));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly ordered ranges of random, extreme or typical values, sometimes inverted
  function automatic face_item_t rnd_face(bit kind, bit last);
    face_item_t it;
    logic [15:0] a, b;
    it.kind = kind;
    it.last = last;
    for (int k = 0; k < 3; k++) begin
      a = rnd16();
      b = rnd16();
      if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) begin
        a ^= b; b ^= a; a ^= b;
      end
      case (k)
        0: begin it.w_lo = a; it.w_hi = b; end
        1: begin it.s_lo = a; it.s_hi = b; end
        default: begin it.g_lo = a; it.g_hi = b; end
      endcase
    end
    return it;
  endfunction

  task automatic random_sets(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(99) < 90 ? $urandom_range(1, 8) : $urandom_range(9, 30);
      for (int i = 0; i < len; i++) begin
        send_item(rnd_face($urandom_range(9) == 0, i == len - 1));
        sent++;
      end
    end
  endtask

  task automatic random_regs();
    write_reg(ffrm_pkg::REG_REQ_WIDTH, rnd16());
    write_reg(ffrm_pkg::REG_REQ_SLOPE, rnd16());
    write_reg(ffrm_pkg::REG_REQ_WEIGHT, rnd16());
    write_reg(ffrm_pkg::REG_NORMAL_STR, rnd16());
    write_reg(ffrm_pkg::REG_ITALIC_THR, 16'($urandom_range(400)));
    write_reg(ffrm_pkg::REG_WSEARCH_LO, rnd16());
    write_reg(ffrm_pkg::REG_WSEARCH_HI, rnd16());
  endtask

  row_t dir_rows[$];

  initial begin
    int guard;
    row_t r;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cur = '0;
    out_stall = 1'b0;
    n_errors = 0;
    n_matches = 0;
    n_found = 0;
    n_overflow = 0;
    hold_off_cycles = 0;
    send_idle_pct = 26;
    recv_idle_pct = 63;
    req_w = 400; req_s = 0; req_g = 1600; norm_str = 400;
    ital_thr = 80; wband_lo = 1600; wband_hi = 2000;
    clear_face_set();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: lone bounds item is an empty set; fixed rows typed in
    r = '0; r.item.kind = 1'b1; r.item.last = 1'b1; r.has_fixed = 1'b1;
    r.fixed = '{8'd0, 1'b0, 1'b0};
    dir_rows.push_back(r);
    r = '0;
    r.item = '{1'b0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1};
    r.has_fixed = 1'b1; r.fixed = '{8'd0, 1'b1, 1'b0};
    dir_rows.push_back(r);
    r = '0; r.item = '{1'b0, 16'h7fff, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0};
    dir_rows.push_back(r);
    r = '0; r.item = '{1'b0, 16'd100, 16'd300, 16'd0, 16'd0, 16'd400, 16'd800, 1'b0};
    dir_rows.push_back(r);
    r = '0;
    r.item = '{1'b0, 16'd500, 16'd600, 16'hffc0, 16'd40, 16'd1600, 16'd2400, 1'b0};
    dir_rows.push_back(r);
    r = '0;
    r.item = '{1'b1, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0};
    dir_rows.push_back(r);
    r = '0;
    r.item = '{1'b1, 16'd0, 16'd800, 16'hff00, 16'd100, 16'd400, 16'd3600, 1'b0};
    dir_rows.push_back(r);
    r = '0;
    r.item = '{1'b0, 16'd400, 16'd400, 16'd80, 16'd80, 16'd2800, 16'd3600, 1'b1};
    dir_rows.push_back(r);
    r = '0;
    r.item = '{1'b0, 16'd400, 16'd400, 16'd0, 16'd0, 16'd1600, 16'd1600, 1'b1};
    r.has_fixed = 1'b1; r.fixed = '{8'd0, 1'b1, 1'b0};
    dir_rows.push_back(r);
    foreach (dir_rows[i]) send_row(dir_rows[i]);

    // Capacity: fill the store, overflow it, then trigger selection
    for (int i = 0; i < NumFaces + 3; i++)
      send_item(rnd_face(1'b0, i == NumFaces + 2));

    // Register extremes with a negative slope request inside the italic threshold, then random sets
    wait_idle();
    write_reg(ffrm_pkg::REG_REQ_WIDTH, 16'h7fff);
    write_reg(ffrm_pkg::REG_REQ_SLOPE, 16'hffd8);
    write_reg(ffrm_pkg::REG_REQ_WEIGHT, 16'h8000);
    write_reg(ffrm_pkg::REG_NORMAL_STR, 16'h8000);
    write_reg(ffrm_pkg::REG_ITALIC_THR, 16'h7fff);
    write_reg(ffrm_pkg::REG_WSEARCH_LO, 16'h8000);
    write_reg(ffrm_pkg::REG_WSEARCH_HI, 16'h7fff);
    random_sets(30);

    wait_idle();
    write_reg(ffrm_pkg::REG_REQ_SLOPE, 16'd20);
    write_reg(ffrm_pkg::REG_ITALIC_THR, 16'd0);
    write_reg(ffrm_pkg::REG_REQ_WEIGHT, 16'd1700);
    write_reg(ffrm_pkg::REG_WSEARCH_LO, 16'd1600);
    write_reg(ffrm_pkg::REG_WSEARCH_HI, 16'd2000);
    random_sets(30);

    // Swap idling; long receiver hold-off fills the block
    wait_idle();
    random_regs();
    send_idle_pct = 63;
    recv_idle_pct = 26;
    hold_off_cycles = 3000;
    random_sets(60);

    wait_idle();
    random_regs();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_sets(60);
    in_valid <= 1'b0;

    guard = 0;
    while (pending_matches.size() != 0 && guard < 500000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (pending_matches.size() != 0) begin
      n_errors++;
      $display("%0d matches never arrived", pending_matches.size());
    end
    $display("covered %0d matches (%0d with a face, %0d overflowed), %0d errors",
             n_matches, n_found, n_overflow, n_errors);
    if (n_errors == 0) $display("** font_face_range_matcher_unit: PASSED **");
    else $display("** font_face_range_matcher_unit: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/ffrm_pkg.sv
design/ffrm_ram.sv
design/ffrm_ctrl.sv
design/ffrm_datapath.sv
design/font_face_range_matcher_unit.sv
design/ffrm_checker.sv
tb/tb.sv
